/* design/bresenham_3d_batched_moves_macros.svh */
// Assertion helpers for the line stepper checker.
// Both expect clk_i and rst_ni in scope.
`ifndef BRESENHAM_3D_BATCHED_MOVES_MACROS_SVH
`define BRESENHAM_3D_BATCHED_MOVES_MACROS_SVH

// consequent checked in the same cycle
`define BBM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bbm assertion failed");

// consequent checked in the next cycle
`define BBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bbm assertion failed");

`endif

/* design/bbm_pkg.sv */
package bbm_pkg;

  localparam int CoordBits    = 16;
  localparam int ErrBits      = CoordBits + 2;
  localparam int CountBits    = CoordBits + 1;
  localparam int QueueDepth   = 4;
  localparam int QueuePtrBits = $clog2(QueueDepth);
  localparam int QueueCntBits = $clog2(QueueDepth + 1);

  localparam logic ActLoad = 1'b0;
  localparam logic ActStep = 1'b1;

  typedef enum logic [1:0] {
    AxisX = 2'd0,
    AxisY = 2'd1,
    AxisZ = 2'd2
  } axis_e;

  typedef logic [CoordBits-1:0]        mag_t;
  typedef logic signed [ErrBits-1:0]   err_t;
  typedef logic signed [CountBits-1:0] count_t;

  // One flush of a step: major batch, then optional single minor moves.
  typedef struct packed {
    axis_e      major;
    logic [2:0] dir_neg;
    mag_t       count;
    logic       need_a;
    logic       need_b;
    logic       final_step;
  } move_rec_t;

  // Minor axes in ascending order.
  function automatic axis_e minor_a(axis_e maj);
    return (maj == AxisX) ? AxisY : AxisX;
  endfunction

  function automatic axis_e minor_b(axis_e maj);
    return (maj == AxisZ) ? AxisY : AxisZ;
  endfunction

endpackage

/* design/bbm_queue.sv */
module bbm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bbm_pkg::move_rec_t  rec_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output bbm_pkg::move_rec_t  rec_o
);

  bbm_pkg::move_rec_t                 mem_q [bbm_pkg::QueueDepth];
  logic [bbm_pkg::QueuePtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [bbm_pkg::QueuePtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [bbm_pkg::QueueCntBits-1:0]   cnt_q, cnt_d;
  logic                               do_push, do_pop;

  localparam logic [bbm_pkg::QueuePtrBits-1:0] LastPtr =
    bbm_pkg::QueuePtrBits'(bbm_pkg::QueueDepth - 1);
  localparam logic [bbm_pkg::QueueCntBits-1:0] FullCnt =
    bbm_pkg::QueueCntBits'(bbm_pkg::QueueDepth);

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

/* design/bbm_front.sv */
module bbm_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 action_i,
  input  logic signed [bbm_pkg::CoordBits-1:0] start_x_i,
  input  logic signed [bbm_pkg::CoordBits-1:0] start_y_i,
  input  logic signed [bbm_pkg::CoordBits-1:0] start_z_i,
  input  logic signed [bbm_pkg::CoordBits-1:0] end_x_i,
  input  logic signed [bbm_pkg::CoordBits-1:0] end_y_i,
  input  logic signed [bbm_pkg::CoordBits-1:0] end_z_i,
  input  logic                                 full_i,
  output logic                                 push_o,
  output bbm_pkg::move_rec_t                   rec_o
);

  logic                busy_q, busy_d;
  bbm_pkg::axis_e      major_q, major_d;
  logic [2:0]          dir_q, dir_d;
  bbm_pkg::mag_t       abs_q [3];
  bbm_pkg::mag_t       abs_d [3];
  bbm_pkg::err_t       err_q [2];
  bbm_pkg::err_t       err_d [2];
  bbm_pkg::mag_t       idx_q, idx_d;
  bbm_pkg::mag_t       pend_q, pend_d;

  logic signed [bbm_pkg::CoordBits-1:0] st [3];
  logic signed [bbm_pkg::CoordBits-1:0] en [3];
  logic signed [bbm_pkg::CoordBits:0]   diff [3];
  logic [2:0]                           ld_neg;
  bbm_pkg::mag_t                        ld_abs [3];
  bbm_pkg::axis_e                       ld_major;
  bbm_pkg::mag_t                        ld_dmaj;

  bbm_pkg::mag_t  dmaj, abs_a, abs_b, idx_n, pend_n;
  bbm_pkg::err_t  ea, eb;
  logic           need_a, need_b, final_step, flush;
  logic           accept, is_step;

  assign st[0] = start_x_i;
  assign st[1] = start_y_i;
  assign st[2] = start_z_i;
  assign en[0] = end_x_i;
  assign en[1] = end_y_i;
  assign en[2] = end_z_i;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign is_step    = (action_i == bbm_pkg::ActStep);

  // Load: deltas, signs and major axis (ties go to the lower axis).
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]   = (bbm_pkg::CoordBits+1)'(en[i]) - (bbm_pkg::CoordBits+1)'(st[i]);
      ld_neg[i] = diff[i][bbm_pkg::CoordBits];
      ld_abs[i] = ld_neg[i] ? bbm_pkg::CoordBits'(-diff[i])
                            : bbm_pkg::CoordBits'(diff[i]);
    end
    if (ld_abs[0] >= ld_abs[1] && ld_abs[0] >= ld_abs[2]) begin
      ld_major = bbm_pkg::AxisX;
    end else if (ld_abs[1] >= ld_abs[2]) begin
      ld_major = bbm_pkg::AxisY;
    end else begin
      ld_major = bbm_pkg::AxisZ;
    end
    ld_dmaj = ld_abs[ld_major];
  end

  // Step: advance one major step and update both minor errors.
  always_comb begin
    dmaj       = abs_q[major_q];
    abs_a      = abs_q[bbm_pkg::minor_a(major_q)];
    abs_b      = abs_q[bbm_pkg::minor_b(major_q)];
    idx_n      = idx_q + 1'b1;
    pend_n     = pend_q + 1'b1;
    ea         = err_q[0] - bbm_pkg::err_t'({2'b00, abs_a});
    eb         = err_q[1] - bbm_pkg::err_t'({2'b00, abs_b});
    need_a     = ea[bbm_pkg::ErrBits-1];
    need_b     = eb[bbm_pkg::ErrBits-1];
    final_step = (idx_n >= dmaj);
    flush      = final_step | need_a | need_b;
  end

  always_comb begin
    busy_d  = busy_q;
    major_d = major_q;
    dir_d   = dir_q;
    abs_d   = abs_q;
    err_d   = err_q;
    idx_d   = idx_q;
    pend_d  = pend_q;
    if (accept && !is_step) begin
      busy_d   = (ld_dmaj != '0);
      major_d  = ld_major;
      dir_d    = ld_neg;
      abs_d    = ld_abs;
      err_d[0] = bbm_pkg::err_t'({2'b00, ld_dmaj >> 1});
      err_d[1] = bbm_pkg::err_t'({2'b00, ld_dmaj >> 1});
      idx_d    = '0;
      pend_d   = '0;
    end else if (accept && busy_q) begin
      idx_d    = idx_n;
      pend_d   = flush ? '0 : pend_n;
      err_d[0] = need_a ? ea + bbm_pkg::err_t'({2'b00, dmaj}) : ea;
      err_d[1] = need_b ? eb + bbm_pkg::err_t'({2'b00, dmaj}) : eb;
      busy_d   = ~final_step;
    end
  end

  assign push_o             = accept & is_step & busy_q & flush;
  assign rec_o.major        = major_q;
  assign rec_o.dir_neg      = dir_q;
  assign rec_o.count        = pend_n;
  assign rec_o.need_a       = need_a;
  assign rec_o.need_b       = need_b;
  assign rec_o.final_step   = final_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      major_q <= bbm_pkg::AxisX;
      dir_q   <= '0;
      abs_q   <= '{default: '0};
      err_q   <= '{default: '0};
      idx_q   <= '0;
      pend_q  <= '0;
    end else begin
      busy_q  <= busy_d;
      major_q <= major_d;
      dir_q   <= dir_d;
      abs_q   <= abs_d;
      err_q   <= err_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
    end
  end

endmodule

/* design/bbm_back.sv */
module bbm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  bbm_pkg::move_rec_t    rec_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            axis_o,
  output bbm_pkg::count_t       steps_o,
  output logic                  last_o
);

  logic             done_maj_q, done_maj_d;
  logic             done_a_q, done_a_d;
  logic             out_valid_q, out_valid_d;
  bbm_pkg::axis_e   axis_q;
  bbm_pkg::count_t  count_q;
  logic             last_q;

  bbm_pkg::axis_e   sel_axis;
  bbm_pkg::mag_t    sel_mag;
  logic             more;
  bbm_pkg::count_t  mag_ext, sel_count;
  logic             advance;

  // Pick the next move of the head record.
  always_comb begin
    if (!done_maj_q) begin
      sel_axis = rec_i.major;
      sel_mag  = rec_i.count;
      more     = rec_i.need_a | rec_i.need_b;
    end else if (rec_i.need_a && !done_a_q) begin
      sel_axis = bbm_pkg::minor_a(rec_i.major);
      sel_mag  = bbm_pkg::mag_t'(1);
      more     = rec_i.need_b;
    end else begin
      sel_axis = bbm_pkg::minor_b(rec_i.major);
      sel_mag  = bbm_pkg::mag_t'(1);
      more     = 1'b0;
    end
    mag_ext   = bbm_pkg::count_t'({1'b0, sel_mag});
    sel_count = rec_i.dir_neg[sel_axis] ? -mag_ext : mag_ext;
  end

  assign advance = valid_i & (~out_valid_q | out_ready_i);
  assign pop_o   = advance & ~more;

  always_comb begin
    done_maj_d  = done_maj_q;
    done_a_d    = done_a_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
      if (!more) begin
        done_maj_d = 1'b0;
        done_a_d   = 1'b0;
      end else begin
        done_maj_d = 1'b1;
        if (done_maj_q) begin
          done_a_d = 1'b1;
        end
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_maj_q  <= 1'b0;
      done_a_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      done_maj_q  <= done_maj_d;
      done_a_q    <= done_a_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      axis_q  <= sel_axis;
      count_q <= sel_count;
      last_q  <= rec_i.final_step & ~more;
    end
  end

  assign out_valid_o = out_valid_q;
  assign axis_o      = axis_q;
  assign steps_o     = count_q;
  assign last_o      = last_q;

endmodule

/* design/bresenham_3d_batched_moves.sv */
// 3D line stepper with batched major-axis moves.
// Input channel (in_valid_i/in_ready_o): a beat with action_i = 0 loads a
// segment from the start and end points; action_i = 1 advances one major step.
// Output channel (out_valid_o/out_ready_i): one move per beat, giving the
// axis, a signed step count and a flag on the segment's final move.
// A step that flushes gives a major batch, then single minor moves in axis
// order: one to three output beats. Loads and non-flushing steps give none.
// A step's moves are registered in the move queue, then in the output
// register, before they show on the outputs.
// Throughput: the front end takes one input beat per cycle while its
// four-entry move queue has room; the back end sends one move per cycle while
// the receiver is ready.
// When the receiver stalls, the output register holds its move, the queue
// fills and in_ready_o drops once it is full.
// Reset clears the segment state, the queue and the output valid; the block
// is ready as soon as reset is released.
module bresenham_3d_batched_moves (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 action_i,
  input  logic signed [bbm_pkg::CoordBits-1:0] start_x_i,
  input  logic signed [bbm_pkg::CoordBits-1:0] start_y_i,
  input  logic signed [bbm_pkg::CoordBits-1:0] start_z_i,
  input  logic signed [bbm_pkg::CoordBits-1:0] end_x_i,
  input  logic signed [bbm_pkg::CoordBits-1:0] end_y_i,
  input  logic signed [bbm_pkg::CoordBits-1:0] end_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           axis_o,
  output logic signed [bbm_pkg::CountBits-1:0] steps_o,
  output logic                                 last_o
);

  logic               push, full, pop, q_valid;
  bbm_pkg::move_rec_t push_rec, head_rec;

  bbm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .start_z_i  (start_z_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .end_z_i    (end_z_i),
    .full_i     (full),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  bbm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rec_o   (head_rec)
  );

  bbm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .rec_i       (head_rec),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .axis_o      (axis_o),
    .steps_o     (steps_o),
    .last_o      (last_o)
  );

endmodule

/* design/bresenham_3d_batched_moves_checker.sv */
`include "bresenham_3d_batched_moves_macros.svh"

module bresenham_3d_batched_moves_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 action_i,
  input logic signed [bbm_pkg::CoordBits-1:0] start_x_i,
  input logic signed [bbm_pkg::CoordBits-1:0] start_y_i,
  input logic signed [bbm_pkg::CoordBits-1:0] start_z_i,
  input logic signed [bbm_pkg::CoordBits-1:0] end_x_i,
  input logic signed [bbm_pkg::CoordBits-1:0] end_y_i,
  input logic signed [bbm_pkg::CoordBits-1:0] end_z_i,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic [1:0]                           axis_o,
  input logic signed [bbm_pkg::CountBits-1:0] steps_o,
  input logic                                 last_o
);

  `BBM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `BBM_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable({axis_o, steps_o, last_o}))
  `BBM_ASSERT_SAME(a_axis_valid, out_valid_o, axis_o <= bbm_pkg::AxisZ)
  `BBM_ASSERT_SAME(a_count_nonzero, out_valid_o, steps_o != '0)

endmodule

bind bresenham_3d_batched_moves bresenham_3d_batched_moves_checker u_checker (.*);
